// ===== rtl/core/rhr_pkg.sv =====
package rhr_pkg;

  localparam int HUE_BITS = 16;
  localparam int UP_SHIFT = (HUE_BITS > 16) ? (HUE_BITS - 16) : 0;
  localparam int DOWN_SHIFT = (HUE_BITS < 16) ? (16 - HUE_BITS) : 0;

  // quotient bits of the two dividers
  localparam int HQ_BITS = HUE_BITS + 1;
  localparam int SQ_BITS = 17;
  localparam int STEPS = (HQ_BITS > SQ_BITS) ? HQ_BITS : SQ_BITS;
  localparam int STEPS_PER_STG = 4;
  localparam int DIV_STG = (STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

  localparam int REM_BITS = 11;            // holds 6*c up to 1530
  localparam int NH_BITS = HUE_BITS + 12;  // hue dividend
  localparam int NS_BITS = 25;             // sat dividend

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_end_in;
  } rhr_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end_out;
  } rhr_out_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [REM_BITS:0] div_step(input logic [REM_BITS-1:0] rem,
                                                 input logic nbit,
                                                 input logic [REM_BITS-1:0] d);
    logic [REM_BITS:0] r2;
    logic [REM_BITS:0] diff;
    r2 = {rem, nbit};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {1'b1, diff[REM_BITS-1:0]};
    end else begin
      div_step = {1'b0, r2[REM_BITS-1:0]};
    end
  endfunction

endpackage

// ===== rtl/core/rgb_hue_rotation_top.sv =====
// RGB hue rotation. Takes one 8-bit RGB word per clock (start high; busy is
// always low, so every start is taken), converts it to hue/saturation/value,
// adds the hue_offset register (1/65536 turn units, wraps at one turn) and
// converts back. Each result appears for exactly one cycle on out_word with
// out_strobe high, in input order; the receiver cannot stall. The pipeline
// holds the input register, prep, the two 17-bit restoring dividers (hue and
// saturation), run as 5 stages of up to 4 steps, hue add, two multiply stages
// and the output register. Gray pixels come out as (v,v,v). Write cfg_data
// with cfg_we only while no words are in flight.
module rgb_hue_rotation_top
  import rhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rhr_in_t     in_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_strobe,
  output rhr_out_t    out_word
);

  localparam int LAT = 5 + DIV_STG;

  logic [15:0] hue_offset_r;

  // input register
  logic    v0_r;
  rhr_in_t w0_r;

  // divider chain, index 0 is the prep stage
  logic                  dv_r    [DIV_STG+1];
  logic [NH_BITS-1:0]    dnh_r   [DIV_STG+1];
  logic [NS_BITS-1:0]    dns_r   [DIV_STG+1];
  logic [REM_BITS-1:0]   dh_r    [DIV_STG+1];
  logic [REM_BITS-1:0]   ds_r    [DIV_STG+1];
  logic [REM_BITS-1:0]   rh_r    [DIV_STG+1];
  logic [REM_BITS-1:0]   rs_r    [DIV_STG+1];
  logic [HQ_BITS-1:0]    qh_r    [DIV_STG+1];
  logic [SQ_BITS-1:0]    qs_r    [DIV_STG+1];
  logic [7:0]            vm_r    [DIV_STG+1];
  logic                  gray_r  [DIV_STG+1];
  logic                  fe_r    [DIV_STG+1];

  logic [NH_BITS-1:0]    dnh_nxt [DIV_STG+1];
  logic [NS_BITS-1:0]    dns_nxt [DIV_STG+1];
  logic [REM_BITS-1:0]   dh_nxt  [DIV_STG+1];
  logic [REM_BITS-1:0]   ds_nxt  [DIV_STG+1];
  logic [REM_BITS-1:0]   rh_nxt  [DIV_STG+1];
  logic [REM_BITS-1:0]   rs_nxt  [DIV_STG+1];
  logic [HQ_BITS-1:0]    qh_nxt  [DIV_STG+1];
  logic [SQ_BITS-1:0]    qs_nxt  [DIV_STG+1];
  logic [7:0]            vm_nxt  [DIV_STG+1];
  logic                  gray_nxt[DIV_STG+1];

  // hue stage
  logic                v3_r, gray3_r, fe3_r;
  logic [7:0]          vm3_r;
  logic [SQ_BITS-1:0]  sat3_r;
  logic [2:0]          sec3_r;
  logic [15:0]         frac3_r;

  // product stage
  logic                v4_r, gray4_r, fe4_r;
  logic [7:0]          vm4_r;
  logic [2:0]          sec4_r;
  logic [32:0]         sf4_r, sg4_r;
  logic [24:0]         pm4_r;

  // channel term stage
  logic                v5_r, gray5_r, fe5_r;
  logic [7:0]          vm5_r, p5_r, q5_r, t5_r;
  logic [2:0]          sec5_r;

  logic     out_strobe_r;
  rhr_out_t out_word_r;

  assign busy = 1'b0;

  // ---------- prep: max, min, chroma, hue numerator, dividends ----------
  logic [7:0]          mx, mn, cc;
  logic [10:0]         num, six_c;
  logic [NH_BITS-1:0]  nh;
  logic [NS_BITS-1:0]  ns;

  always_comb begin
    mx = w0_r.red_in;
    if (w0_r.green_in > mx) mx = w0_r.green_in;
    if (w0_r.blue_in > mx) mx = w0_r.blue_in;
    mn = w0_r.red_in;
    if (w0_r.green_in < mn) mn = w0_r.green_in;
    if (w0_r.blue_in < mn) mn = w0_r.blue_in;
    cc = mx - mn;
    six_c = {2'b0, cc, 1'b0} + {1'b0, cc, 2'b0};
    if (mx == w0_r.red_in) begin
      if (w0_r.green_in >= w0_r.blue_in) begin
        num = {3'b0, w0_r.green_in - w0_r.blue_in};
      end else begin
        num = six_c - {3'b0, w0_r.blue_in - w0_r.green_in};
      end
    end else if (mx == w0_r.green_in) begin
      num = {2'b0, cc, 1'b0} + {3'b0, w0_r.blue_in} - {3'b0, w0_r.red_in};
    end else begin
      num = {1'b0, cc, 2'b0} + {3'b0, w0_r.red_in} - {3'b0, w0_r.green_in};
    end
    nh = ({{(NH_BITS-11){1'b0}}, num} << HUE_BITS)
       + {{(NH_BITS-9){1'b0}}, cc, 1'b0} + {{(NH_BITS-8){1'b0}}, cc};
    ns = {1'b0, cc, 16'b0} + {18'b0, mx[7:1]};
  end

  // ---------- divider stages, up to 4 steps each ----------
  always_comb begin
    logic [REM_BITS:0] st;
    st = '0;
    dnh_nxt[0]  = nh;
    dns_nxt[0]  = ns;
    dh_nxt[0]   = six_c;
    ds_nxt[0]   = {3'b0, mx};
    rh_nxt[0]   = REM_BITS'(nh >> HQ_BITS);
    rs_nxt[0]   = REM_BITS'(ns >> SQ_BITS);
    qh_nxt[0]   = '0;
    qs_nxt[0]   = '0;
    vm_nxt[0]   = mx;
    gray_nxt[0] = (cc == 8'd0);
    for (int s = 1; s <= DIV_STG; s++) begin
      dnh_nxt[s]  = dnh_r[s-1];
      dns_nxt[s]  = dns_r[s-1];
      dh_nxt[s]   = dh_r[s-1];
      ds_nxt[s]   = ds_r[s-1];
      rh_nxt[s]   = rh_r[s-1];
      rs_nxt[s]   = rs_r[s-1];
      qh_nxt[s]   = qh_r[s-1];
      qs_nxt[s]   = qs_r[s-1];
      vm_nxt[s]   = vm_r[s-1];
      gray_nxt[s] = gray_r[s-1];
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        if ((s - 1) * STEPS_PER_STG + j < STEPS) begin
          if (STEPS - 1 - ((s - 1) * STEPS_PER_STG + j) < HQ_BITS) begin
            st = div_step(rh_nxt[s],
                          dnh_r[s-1][STEPS - 1 - ((s - 1) * STEPS_PER_STG + j)],
                          dh_r[s-1]);
            rh_nxt[s] = st[REM_BITS-1:0];
            qh_nxt[s][STEPS - 1 - ((s - 1) * STEPS_PER_STG + j)] = st[REM_BITS];
          end
          if (STEPS - 1 - ((s - 1) * STEPS_PER_STG + j) < SQ_BITS) begin
            st = div_step(rs_nxt[s],
                          dns_r[s-1][STEPS - 1 - ((s - 1) * STEPS_PER_STG + j)],
                          ds_r[s-1]);
            rs_nxt[s] = st[REM_BITS-1:0];
            qs_nxt[s][STEPS - 1 - ((s - 1) * STEPS_PER_STG + j)] = st[REM_BITS];
          end
        end
      end
    end
  end

  // ---------- hue add, sector and fraction ----------
  logic [HUE_BITS-1:0] hue, off_h, hue2;
  logic [HUE_BITS+2:0] h6;
  logic [47:0]         off_w, frac_w;

  always_comb begin
    hue    = qh_r[DIV_STG][HUE_BITS-1:0];
    off_w  = ({32'b0, hue_offset_r} << UP_SHIFT) >> DOWN_SHIFT;
    off_h  = off_w[HUE_BITS-1:0];
    hue2   = hue + off_h;
    h6     = {1'b0, hue2, 2'b0} + {2'b0, hue2, 1'b0};
    frac_w = ({{(48-HUE_BITS){1'b0}}, h6[HUE_BITS-1:0]} << DOWN_SHIFT) >> UP_SHIFT;
  end

  // ---------- channel terms ----------
  logic [40:0] qp, tp;
  logic [24:0] pp;
  logic [32:0] one32;

  always_comb begin
    one32 = {1'b1, 32'b0};
    qp = {33'b0, vm4_r} * (one32 - sf4_r) + {9'b0, 1'b1, 31'b0};
    tp = {33'b0, vm4_r} * (one32 - sg4_r) + {9'b0, 1'b1, 31'b0};
    pp = pm4_r + 25'h8000;
  end

  // ---------- output select ----------
  rhr_out_t sel;
  always_comb begin
    sel.frame_end_out = fe5_r;
    if (gray5_r) begin
      sel.red_out = vm5_r; sel.green_out = vm5_r; sel.blue_out = vm5_r;
    end else begin
      case (sec5_r)
        3'd0: begin
          sel.red_out = vm5_r; sel.green_out = t5_r; sel.blue_out = p5_r;
        end
        3'd1: begin
          sel.red_out = q5_r; sel.green_out = vm5_r; sel.blue_out = p5_r;
        end
        3'd2: begin
          sel.red_out = p5_r; sel.green_out = vm5_r; sel.blue_out = t5_r;
        end
        3'd3: begin
          sel.red_out = p5_r; sel.green_out = q5_r; sel.blue_out = vm5_r;
        end
        3'd4: begin
          sel.red_out = t5_r; sel.green_out = p5_r; sel.blue_out = vm5_r;
        end
        default: begin
          sel.red_out = vm5_r; sel.green_out = p5_r; sel.blue_out = q5_r;
        end
      endcase
    end
  end

  // ---------- control registers ----------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r <= '0;
      v0_r <= 1'b0;
      for (int s = 0; s <= DIV_STG; s++) dv_r[s] <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) hue_offset_r <= cfg_data;
      v0_r <= start;
      dv_r[0] <= v0_r;
      for (int s = 1; s <= DIV_STG; s++) dv_r[s] <= dv_r[s-1];
      v3_r <= dv_r[DIV_STG];
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_strobe_r <= v5_r;
    end
  end

  // ---------- payload registers ----------
  always_ff @(posedge clk) begin
    w0_r <= in_word;
    fe_r[0] <= w0_r.frame_end_in;
    for (int s = 0; s <= DIV_STG; s++) begin
      dnh_r[s]  <= dnh_nxt[s];
      dns_r[s]  <= dns_nxt[s];
      dh_r[s]   <= dh_nxt[s];
      ds_r[s]   <= ds_nxt[s];
      rh_r[s]   <= rh_nxt[s];
      rs_r[s]   <= rs_nxt[s];
      qh_r[s]   <= qh_nxt[s];
      qs_r[s]   <= qs_nxt[s];
      vm_r[s]   <= vm_nxt[s];
      gray_r[s] <= gray_nxt[s];
    end
    for (int s = 1; s <= DIV_STG; s++) fe_r[s] <= fe_r[s-1];

    vm3_r   <= vm_r[DIV_STG];
    gray3_r <= gray_r[DIV_STG];
    fe3_r   <= fe_r[DIV_STG];
    sat3_r  <= qs_r[DIV_STG];
    sec3_r  <= h6[HUE_BITS+2:HUE_BITS];
    frac3_r <= frac_w[15:0];

    vm4_r   <= vm3_r;
    gray4_r <= gray3_r;
    fe4_r   <= fe3_r;
    sec4_r  <= sec3_r;
    sf4_r   <= sat3_r * {1'b0, frac3_r};
    sg4_r   <= sat3_r * (17'h10000 - {1'b0, frac3_r});
    pm4_r   <= {17'b0, vm3_r} * (25'h10000 - {8'b0, sat3_r});

    vm5_r   <= vm4_r;
    gray5_r <= gray4_r;
    fe5_r   <= fe4_r;
    sec5_r  <= sec4_r;
    q5_r    <= qp[39:32];
    t5_r    <= tp[39:32];
    p5_r    <= pp[23:16];

    out_word_r <= sel;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // ---------- checks ----------
  // every accepted word must emerge with out_strobe high after the full pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |-> ##(LAT + 1) out_strobe)
    else $error("accepted word did not emerge on time");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && gray5_r |=> out_word.red_out == out_word.green_out &&
                        out_word.green_out == out_word.blue_out)
    else $error("gray pixel lost its value");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> sec3_r <= 3'd5)
    else $error("hue sector out of range");

endmodule

// ===== test/tb_rgb_hue_rotation_top.sv =====
module tb_rgb_hue_rotation_top;
  import rhr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth of the block; used for settle gaps.
  localparam int LATENCY = 10;
  localparam int SETTLE = LATENCY + 6;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rhr_in_t in_word;
  logic cfg_we;
  logic [15:0] cfg_data;
  logic out_strobe;
  rhr_out_t out_word;

  rgb_hue_rotation_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .out_strobe(out_strobe),
    .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Expected rotated pixels, oldest first.
  rhr_out_t pending_pixels[$];
  logic [15:0] hue_shift;
  int mismatch_count;
  int pixels_sent;
  int pixels_seen;
  bit idle_gaps;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] error: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Fixed-point HSV round trip with hue offset; all math at 64 bits.
  function automatic rhr_out_t rotate_pixel(input rhr_in_t px, input logic [15:0] shift);
    longint r, g, b, mx, mn, c, num;
    longint unsigned hue, sat, h6, sector, frac, p, q, t, v, hmask;
    rhr_out_t res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    hmask = (64'd1 << HUE_BITS) - 1;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    v = mx;
    res.frame_end_out = px.frame_end_in;
    if (c == 0) begin
      // gray (and black): every channel is the value
      res.red_out = v[7:0];
      res.green_out = v[7:0];
      res.blue_out = v[7:0];
      return res;
    end
    if (mx == r) begin
      num = g - b;
      if (num < 0) num += 6 * c;
    end else if (mx == g) begin
      num = 2 * c + (b - r);
    end else begin
      num = 4 * c + (r - g);
    end
    hue = ((longint'(num) << HUE_BITS) + 3 * c) / (6 * c);
    hue &= hmask;
    sat = ((longint'(c) << 16) + v / 2) / v;
    hue = (hue + ((((64'(shift)) << UP_SHIFT) >> DOWN_SHIFT) & hmask)) & hmask;
    h6 = hue * 6;
    sector = h6 >> HUE_BITS;
    frac = (((h6 & hmask) << DOWN_SHIFT) >> UP_SHIFT) & 64'hFFFF;
    p = (v * (65536 - sat) + 32768) >> 16;
    q = (v * ((64'd1 << 32) - sat * frac) + (64'd1 << 31)) >> 32;
    t = (v * ((64'd1 << 32) - sat * (65536 - frac)) + (64'd1 << 31)) >> 32;
    case (sector)
      0: begin res.red_out = v[7:0]; res.green_out = t[7:0]; res.blue_out = p[7:0]; end
      1: begin res.red_out = q[7:0]; res.green_out = v[7:0]; res.blue_out = p[7:0]; end
      2: begin res.red_out = p[7:0]; res.green_out = v[7:0]; res.blue_out = t[7:0]; end
      3: begin res.red_out = p[7:0]; res.green_out = q[7:0]; res.blue_out = v[7:0]; end
      4: begin res.red_out = t[7:0]; res.green_out = p[7:0]; res.blue_out = v[7:0]; end
      default: begin
        res.red_out = v[7:0]; res.green_out = p[7:0]; res.blue_out = q[7:0];
      end
    endcase
    return res;
  endfunction

  // Output monitor: strobe is sampled on the edge that closes its cycle.
  always @(posedge clk) begin
    rhr_out_t want;
    if (rst_n && out_strobe) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word, pixel", pixels_seen, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_word.red_out !== want.red_out)
          report_mismatch("red_out", out_word.red_out, want.red_out);
        if (out_word.green_out !== want.green_out)
          report_mismatch("green_out", out_word.green_out, want.green_out);
        if (out_word.blue_out !== want.blue_out)
          report_mismatch("blue_out", out_word.blue_out, want.blue_out);
        if (out_word.frame_end_out !== want.frame_end_out)
          report_mismatch("frame_end_out", out_word.frame_end_out, want.frame_end_out);
      end
    end
  end

  // Send one word; the prediction is queued on the accepting edge. Start
  // stays high across back-to-back words, so it is only lowered on a gap.
  task automatic send_pixel(input rhr_in_t px, input bit has_want, input rhr_out_t want);
    int gap;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (has_want) pending_pixels.push_back(want);
    else pending_pixels.push_back(rotate_pixel(px, hue_shift));
    pixels_sent++;
  endtask

  // Drain, let the pipe empty, then write the offset register.
  task automatic set_hue_shift(input logic [15:0] val);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    hue_shift = val;
    @(posedge clk);
  endtask

  // Directed rows: extremes, gray/black, each sector, hue wrap, rounding.
  // Typed results only for gray/black rows; others go through the predictor.
  typedef struct {
    rhr_in_t px;
    bit has_want;
    rhr_out_t want;
  } pixel_row_t;

  pixel_row_t pixel_rows[] = '{
    '{'{8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b1, '{8'd128, 8'd128, 8'd128, 1'b0}},
    '{'{8'd1, 8'd1, 8'd1, 1'b1}, 1'b1, '{8'd1, 8'd1, 8'd1, 1'b1}},
    '{'{8'd255, 8'd0, 8'd0, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd0, 8'd0, 8'd255, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd255, 8'd0, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd0, 8'd255, 8'd255, 1'b1}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd0, 8'd1, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd254, 8'd255, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd1, 8'd0, 8'd0, 1'b1}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd200, 8'd100, 8'd50, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd50, 8'd200, 8'd100, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd100, 8'd50, 8'd200, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd170, 8'd85, 8'd85, 1'b1}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd254, 8'd1, 8'd255, 1'b0}, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}}
  };

  logic [15:0] shift_plan[] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h2AAB};

  rhr_in_t rnd_px;
  rhr_out_t dummy;
  int kind;

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hue_shift = 16'h0000;
    mismatch_count = 0;
    pixels_sent = 0;
    pixels_seen = 0;
    idle_gaps = 1'b1;
    dummy = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at reset offset, then again at FFFF, 8000, 0001 and 2AAB.
    foreach (shift_plan[s]) begin
      if (s != 0) set_hue_shift(shift_plan[s]);
      foreach (pixel_rows[i]) send_pixel(pixel_rows[i].px, pixel_rows[i].has_want,
                                         pixel_rows[i].want);
    end

    // Random part: ~800 words in phases with new offsets; last phase runs gapless.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_gaps = 1'b0;
      set_hue_shift((ph % 3 == 0) ? 16'($urandom) :
                    (ph % 3 == 1) ? 16'($urandom_range(0, 15)) : 16'hFFFF - 16'($urandom_range(0, 15)));
      repeat (100) begin
        kind = $urandom_range(0, 9);
        rnd_px.red_in = 8'($urandom);
        rnd_px.green_in = 8'($urandom);
        rnd_px.blue_in = 8'($urandom);
        rnd_px.frame_end_in = ($urandom_range(0, 15) == 0);
        if (kind == 0) begin
          // gray pixel
          rnd_px.green_in = rnd_px.red_in;
          rnd_px.blue_in = rnd_px.red_in;
        end else if (kind == 1) begin
          // tie between red and green
          rnd_px.green_in = rnd_px.red_in;
        end else if (kind == 2) begin
          // red and green differ only in the lowest bit
          rnd_px.green_in = rnd_px.red_in ^ 8'h01;
        end
        send_pixel(rnd_px, 1'b0, dummy);
      end
    end

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d pixels (%0d checked) across %0d hue offsets incl. 0 and FFFF,",
             pixels_sent, pixels_seen, shift_plan.size() + 8);
    $display("gray, black, primaries, ties and hue wrap, with and without input gaps.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far above ~1000 words with gaps plus drains.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
